// ===== sv/plmc_pkg.sv =====
// Package: shared types and constants of the press length mode controller.
`timescale 1ns / 1ps

package plmc_pkg;

    // Widths of the press length and the configuration port
    localparam int TICK_W  = 16;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_SHORT_MIN   = 3'd0;
    localparam logic [2:0] REG_SHORT_MAX   = 3'd1;
    localparam logic [2:0] REG_LONG_MIN    = 3'd2;
    localparam logic [2:0] REG_LONG_MAX    = 3'd3;
    localparam logic [2:0] REG_STANDBY_MIN = 3'd4;

    // Threshold reset values in 100 us ticks
    localparam logic [TICK_W-1:0] SHORT_MIN_RST   = 16'd100;
    localparam logic [TICK_W-1:0] SHORT_MAX_RST   = 16'd10000;
    localparam logic [TICK_W-1:0] LONG_MIN_RST    = 16'd15000;
    localparam logic [TICK_W-1:0] LONG_MAX_RST    = 16'd30000;
    localparam logic [TICK_W-1:0] STANDBY_MIN_RST = 16'd40000;

    // Mode codes
    localparam logic [3:0] MODE_TEMP      = 4'd0;
    localparam logic [3:0] MODE_TIME      = 4'd1;
    localparam logic [3:0] MODE_DATE      = 4'd2;
    localparam logic [3:0] MODE_SET_HOUR  = 4'd3;
    localparam logic [3:0] MODE_SET_MIN   = 4'd4;
    localparam logic [3:0] MODE_SET_DAY   = 4'd5;
    localparam logic [3:0] MODE_SET_MONTH = 4'd6;
    localparam logic [3:0] MODE_SET_YEAR  = 4'd7;
    localparam logic [3:0] MODE_STANDBY   = 4'd8;

    // Edit field limits; tops are one bit wider than the field
    localparam logic [5:0] HOUR_TOP      = 6'd23;
    localparam logic [4:0] HOUR_RESTART  = 5'd0;
    localparam logic [6:0] MIN_TOP       = 7'd59;
    localparam logic [5:0] MIN_RESTART   = 6'd0;
    localparam logic [5:0] DAY_TOP       = 6'd31;
    localparam logic [4:0] DAY_RESTART   = 5'd1;
    localparam logic [4:0] MONTH_TOP     = 5'd12;
    localparam logic [3:0] MONTH_RESTART = 4'd1;
    localparam logic [7:0] YEAR_TOP      = 8'd30;
    localparam logic [6:0] YEAR_RESTART  = 7'd20;

    // Input word: one finished press plus the clock time and date
    typedef struct packed {
        logic [TICK_W-1:0] press_ticks;
        logic [4:0]        cur_hour;
        logic [5:0]        cur_minute;
        logic [4:0]        cur_day;
        logic [3:0]        cur_month;
        logic [6:0]        cur_year;
    } press_word_t;

    // Result word
    typedef struct packed {
        logic [3:0] mode;
        logic       redraw;
        logic [4:0] edit_hour;
        logic [5:0] edit_minute;
        logic [4:0] edit_day;
        logic [3:0] edit_month;
        logic [6:0] edit_year;
        logic       commit;
    } result_word_t;

endpackage

// ===== sv/plmc_if.sv =====
// Interfaces: valid/ready channels for press words and result words.
`timescale 1ns / 1ps

interface plmc_in_if import plmc_pkg::*; ();
    logic        valid;
    logic        ready;
    press_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface plmc_out_if import plmc_pkg::*; ();
    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/press_length_mode_controller.sv =====
// Top level: single-button watch mode controller with APB threshold registers.
`timescale 1ns / 1ps

// Each press word is classified as short, long or standby against five
// threshold registers and then updates the mode and the time/date edit
// fields; exactly one result word comes out per press. A press word is
// taken every cycle when the result side keeps ready high: it lands in an
// input register, passes one stage of compare-and-update logic (the mode
// and edit registers are written at the same edge), and the result sits in
// an output register; throughput is then one word per cycle. Thresholds
// are written over APB at byte address 4 * index and should only change
// while no press is in flight.
module press_length_mode_controller import plmc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Word channels
    plmc_in_if.sink            press,
    plmc_out_if.source         result
);

    // Threshold registers
    logic [TICK_W-1:0] short_min_reg;
    logic [TICK_W-1:0] short_max_reg;
    logic [TICK_W-1:0] long_min_reg;
    logic [TICK_W-1:0] long_max_reg;
    logic [TICK_W-1:0] standby_min_reg;

    // Pipeline registers
    logic         in_valid_reg;
    press_word_t  in_word_reg;
    logic         out_valid_reg;
    result_word_t out_word_reg;

    // Mode and edit state
    logic [3:0] mode_reg,  mode_next;
    logic [4:0] hour_reg,  hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [4:0] day_reg,   day_next;
    logic [3:0] month_reg, month_next;
    logic [6:0] year_reg,  year_next;
    logic       redraw_next;
    logic       commit_next;

    logic       cfg_wr;
    logic [2:0] cfg_idx;
    logic       advance;
    logic       is_short;
    logic       is_long;
    logic       is_standby;
    logic       in_setting;

    logic [5:0] hour_inc;
    logic [6:0] minute_inc;
    logic [5:0] day_inc;
    logic [4:0] month_inc;
    logic [7:0] year_inc;

    // APB access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg   <= SHORT_MIN_RST;
            short_max_reg   <= SHORT_MAX_RST;
            long_min_reg    <= LONG_MIN_RST;
            long_max_reg    <= LONG_MAX_RST;
            standby_min_reg <= STANDBY_MIN_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SHORT_MIN:   short_min_reg   <= pwdata[TICK_W-1:0];
                REG_SHORT_MAX:   short_max_reg   <= pwdata[TICK_W-1:0];
                REG_LONG_MIN:    long_min_reg    <= pwdata[TICK_W-1:0];
                REG_LONG_MAX:    long_max_reg    <= pwdata[TICK_W-1:0];
                REG_STANDBY_MIN: standby_min_reg <= pwdata[TICK_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            REG_SHORT_MIN:   prdata[TICK_W-1:0] = short_min_reg;
            REG_SHORT_MAX:   prdata[TICK_W-1:0] = short_max_reg;
            REG_LONG_MIN:    prdata[TICK_W-1:0] = long_min_reg;
            REG_LONG_MAX:    prdata[TICK_W-1:0] = long_max_reg;
            REG_STANDBY_MIN: prdata[TICK_W-1:0] = standby_min_reg;
            default:         prdata = '0;
        endcase
    end

    // Flow control: input stage moves on when the output stage is free
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign press.ready  = !in_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

    // Press classification
    assign is_short   = (in_word_reg.press_ticks >= short_min_reg)
                     && (in_word_reg.press_ticks <= short_max_reg);
    assign is_long    = (in_word_reg.press_ticks > long_min_reg)
                     && (in_word_reg.press_ticks <= long_max_reg);
    assign is_standby = (in_word_reg.press_ticks >= standby_min_reg);
    assign in_setting = (mode_reg >= MODE_SET_HOUR) && (mode_reg <= MODE_SET_YEAR);

    // Field increments, one bit wider to catch the wrap
    assign hour_inc   = {1'b0, hour_reg} + 6'd1;
    assign minute_inc = {1'b0, minute_reg} + 7'd1;
    assign day_inc    = {1'b0, day_reg} + 6'd1;
    assign month_inc  = {1'b0, month_reg} + 5'd1;
    assign year_inc   = {1'b0, year_reg} + 8'd1;

    // Mode and edit field update
    always_comb
    begin
        mode_next   = mode_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        redraw_next = 1'b0;
        commit_next = 1'b0;
        if (in_setting)
        begin
            if (is_short)
            begin
                case (mode_reg)
                    MODE_SET_HOUR:
                    begin
                        if (hour_inc > HOUR_TOP)
                        begin
                            hour_next   = HOUR_RESTART;
                            redraw_next = 1'b1;
                        end
                        else
                            hour_next = hour_inc[4:0];
                    end
                    MODE_SET_MIN:
                    begin
                        if (minute_inc > MIN_TOP)
                        begin
                            minute_next = MIN_RESTART;
                            redraw_next = 1'b1;
                        end
                        else
                            minute_next = minute_inc[5:0];
                    end
                    MODE_SET_DAY:
                    begin
                        if (day_inc > DAY_TOP)
                        begin
                            day_next    = DAY_RESTART;
                            redraw_next = 1'b1;
                        end
                        else
                            day_next = day_inc[4:0];
                    end
                    MODE_SET_MONTH:
                    begin
                        if (month_inc > MONTH_TOP)
                        begin
                            month_next  = MONTH_RESTART;
                            redraw_next = 1'b1;
                        end
                        else
                            month_next = month_inc[3:0];
                    end
                    default:
                    begin
                        if (year_inc > YEAR_TOP)
                        begin
                            year_next   = YEAR_RESTART;
                            redraw_next = 1'b1;
                        end
                        else
                            year_next = year_inc[6:0];
                    end
                endcase
            end
            else if (is_long)
            begin
                redraw_next = 1'b1;
                if (mode_reg == MODE_SET_YEAR)
                begin
                    mode_next   = MODE_TEMP;
                    commit_next = 1'b1;
                end
                else
                    mode_next = mode_reg + 4'd1;
            end
        end
        else
        begin
            if (is_short)
            begin
                if (mode_reg <= MODE_DATE)
                begin
                    mode_next   = (mode_reg == MODE_DATE) ? MODE_TEMP : mode_reg + 4'd1;
                    redraw_next = 1'b1;
                end
            end
            else if (is_long && (mode_reg == MODE_TIME || mode_reg == MODE_DATE))
            begin
                // Enter hour setting with the clock values
                mode_next   = MODE_SET_HOUR;
                redraw_next = 1'b1;
                hour_next   = in_word_reg.cur_hour;
                minute_next = in_word_reg.cur_minute;
                day_next    = in_word_reg.cur_day;
                month_next  = in_word_reg.cur_month;
                year_next   = in_word_reg.cur_year;
            end
            else if (is_standby)
                mode_next = MODE_STANDBY;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
        end
        else
        begin
            if (press.ready)
                in_valid_reg <= press.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                mode_reg   <= mode_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                day_reg    <= day_next;
                month_reg  <= month_next;
                year_reg   <= year_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (press.valid && press.ready)
            in_word_reg <= press.data;
        if (advance)
        begin
            out_word_reg.mode        <= mode_next;
            out_word_reg.redraw      <= redraw_next;
            out_word_reg.edit_hour   <= hour_next;
            out_word_reg.edit_minute <= minute_next;
            out_word_reg.edit_day    <= day_next;
            out_word_reg.edit_month  <= month_next;
            out_word_reg.edit_year   <= year_next;
            out_word_reg.commit      <= commit_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Mode never leaves the defined codes
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg <= MODE_STANDBY)
        else $error("mode register out of range");

    // State only changes when a word moves to the output stage
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(mode_reg) && $stable(hour_reg) && $stable(year_reg))
        else $error("state changed without a word");

    // A commit always returns to mode 0 with a redraw
    a_commit_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.commit |->
            out_word_reg.mode == MODE_TEMP && out_word_reg.redraw)
        else $error("commit without return to mode 0");

    // Result word mirrors the state it left behind
    a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_word_reg.mode == mode_reg && out_word_reg.edit_hour == hour_reg)
        else $error("result word differs from state");
`endif

endmodule
